>>> sv/http_chunked_body_decoder_core_assert.svh
// Assertion macros for the chunked body decoder checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH

// Assertion that is checked only outside reset.
`define HCBD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hcbd assertion failed");

// Assertion that is checked during reset too.
`define HCBD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hcbd assertion failed");

`endif

>>> sv/hcbd_pkg.sv
// Package for the HTTP chunked body decoder: phase type, result kinds,
// byte codes and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    localparam int COUNT_BITS_DEF = 31;
    localparam int HEX_BITS       = 4;

    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_COLON = 8'd58;

    localparam logic [2:0] KIND_BODY        = 3'd0;
    localparam logic [2:0] KIND_TRAILER     = 3'd1;
    localparam logic [2:0] KIND_LINE_END    = 3'd2;
    localparam logic [2:0] KIND_COMPLETE    = 3'd3;
    localparam logic [2:0] KIND_SIZE_ERR    = 3'd4;
    localparam logic [2:0] KIND_TRAILER_ERR = 3'd5;

    typedef enum logic [3:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_TRL,
        PH_TRL_LF,
        PH_END_LF,
        PH_DONE,
        PH_ERR
    } t_phase;

    // Returns {is_digit, value}.
    function automatic logic [HEX_BITS:0] hex_decode(input logic [7:0] b);
        logic [HEX_BITS:0] r;
        r = '0;
        if (b >= 8'd48 && b <= 8'd57) begin
            r = {1'b1, 4'(b - 8'd48)};
        end else if (b >= 8'd65 && b <= 8'd70) begin
            r = {1'b1, 4'(b - 8'd55)};
        end else if (b >= 8'd97 && b <= 8'd102) begin
            r = {1'b1, 4'(b - 8'd87)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/http_chunked_body_decoder_core.sv
// An accepted item passes through the input register and then the result register; a stalled output holds both.
// Throughput: one item per cycle while the output is not stalled; the single decode stage between the input
// register and the result register updates the phase state for each item it passes on.
// Items that yield no result simply leave the pipeline without an output.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to reading a chunk size line.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_core
    import hcbd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_restart,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_kind
);

    logic                    r_s0_valid;
    logic [7:0]              r_s0_byte;
    logic                    r_s0_restart;

    t_phase                  r_phase, n_phase, cur_phase;
    logic [COUNT_BITS-1:0]   r_rem, n_rem, cur_rem;
    logic                    r_digit, n_digit, cur_digit;
    logic                    r_colon, n_colon, cur_colon;
    logic                    r_nonempty, n_nonempty, cur_nonempty;

    logic                    r_out_valid;
    logic [7:0]              r_out_byte;
    logic [2:0]              r_out_kind;

    logic                    out_free;
    logic                    fire;
    logic                    emit;
    logic [7:0]              emit_byte;
    logic [2:0]              emit_kind;
    logic [HEX_BITS:0]       hex;
    logic                    overflow;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_s0_valid && out_free;
    assign o_in_ready = !r_s0_valid || out_free;

    assign cur_phase    = r_s0_restart ? PH_SIZE : r_phase;
    assign cur_rem      = r_s0_restart ? '0 : r_rem;
    assign cur_digit    = r_s0_restart ? 1'b0 : r_digit;
    assign cur_colon    = r_s0_restart ? 1'b0 : r_colon;
    assign cur_nonempty = r_s0_restart ? 1'b0 : r_nonempty;

    assign hex      = hex_decode(r_s0_byte);
    assign overflow = |cur_rem[COUNT_BITS-1 -: HEX_BITS];

    always_comb begin
        n_phase    = cur_phase;
        n_rem      = cur_rem;
        n_digit    = cur_digit;
        n_colon    = cur_colon;
        n_nonempty = cur_nonempty;
        case (cur_phase)
            PH_SIZE: begin
                if (r_s0_byte == BYTE_CR) begin
                    n_phase = PH_SIZE_LF;
                end else if (!hex[HEX_BITS] || overflow) begin
                    n_phase = PH_ERR;
                end else begin
                    n_rem   = {cur_rem[COUNT_BITS-HEX_BITS-1:0], hex[HEX_BITS-1:0]};
                    n_digit = 1'b1;
                end
            end
            PH_SIZE_LF: begin
                if (r_s0_byte != BYTE_LF || !cur_digit) begin
                    n_phase = PH_ERR;
                end else begin
                    n_digit = 1'b0;
                    if (cur_rem != '0) begin
                        n_phase = PH_DATA;
                    end else begin
                        n_phase    = PH_TRL;
                        n_colon    = 1'b0;
                        n_nonempty = 1'b0;
                    end
                end
            end
            PH_DATA: begin
                n_rem = cur_rem - COUNT_BITS'(1);
                if (cur_rem == COUNT_BITS'(1)) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = (r_s0_byte == BYTE_CR) ? PH_DATA_LF : PH_ERR;
            end
            PH_DATA_LF: begin
                if (r_s0_byte != BYTE_LF) begin
                    n_phase = PH_ERR;
                end else begin
                    n_phase = PH_SIZE;
                    n_rem   = '0;
                    n_digit = 1'b0;
                end
            end
            PH_TRL: begin
                if (r_s0_byte == BYTE_CR) begin
                    if (!cur_nonempty) begin
                        n_phase = PH_END_LF;
                    end else if (!cur_colon) begin
                        n_phase = PH_ERR;
                    end else begin
                        n_phase = PH_TRL_LF;
                    end
                end else if (r_s0_byte == BYTE_COLON && !cur_colon && !cur_nonempty) begin
                    n_phase = PH_ERR;
                end else begin
                    if (r_s0_byte == BYTE_COLON) begin
                        n_colon = 1'b1;
                    end
                    n_nonempty = 1'b1;
                end
            end
            PH_TRL_LF: begin
                if (r_s0_byte != BYTE_LF) begin
                    n_phase = PH_ERR;
                end else begin
                    n_phase    = PH_TRL;
                    n_colon    = 1'b0;
                    n_nonempty = 1'b0;
                end
            end
            PH_END_LF: begin
                n_phase = (r_s0_byte == BYTE_LF) ? PH_DONE : PH_ERR;
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    always_comb begin
        emit      = 1'b0;
        emit_byte = '0;
        emit_kind = KIND_BODY;
        case (cur_phase)
            PH_SIZE: begin
                if (r_s0_byte != BYTE_CR && (!hex[HEX_BITS] || overflow)) begin
                    emit      = 1'b1;
                    emit_kind = KIND_SIZE_ERR;
                end
            end
            PH_SIZE_LF: begin
                if (r_s0_byte != BYTE_LF || !cur_digit) begin
                    emit      = 1'b1;
                    emit_kind = KIND_SIZE_ERR;
                end
            end
            PH_DATA: begin
                emit      = 1'b1;
                emit_byte = r_s0_byte;
                emit_kind = KIND_BODY;
            end
            PH_DATA_CR: begin
                if (r_s0_byte != BYTE_CR) begin
                    emit      = 1'b1;
                    emit_kind = KIND_SIZE_ERR;
                end
            end
            PH_DATA_LF: begin
                if (r_s0_byte != BYTE_LF) begin
                    emit      = 1'b1;
                    emit_kind = KIND_SIZE_ERR;
                end
            end
            PH_TRL: begin
                if (r_s0_byte == BYTE_CR) begin
                    if (cur_nonempty && !cur_colon) begin
                        emit      = 1'b1;
                        emit_kind = KIND_TRAILER_ERR;
                    end
                end else if (r_s0_byte == BYTE_COLON && !cur_colon && !cur_nonempty) begin
                    emit      = 1'b1;
                    emit_kind = KIND_TRAILER_ERR;
                end else begin
                    emit      = 1'b1;
                    emit_byte = r_s0_byte;
                    emit_kind = KIND_TRAILER;
                end
            end
            PH_TRL_LF: begin
                emit      = 1'b1;
                emit_kind = (r_s0_byte == BYTE_LF) ? KIND_LINE_END : KIND_TRAILER_ERR;
            end
            PH_END_LF: begin
                emit      = 1'b1;
                emit_kind = (r_s0_byte == BYTE_LF) ? KIND_COMPLETE : KIND_TRAILER_ERR;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s0_byte    <= i_in_byte;
            r_s0_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIZE;
            r_rem      <= '0;
            r_digit    <= 1'b0;
            r_colon    <= 1'b0;
            r_nonempty <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_rem      <= n_rem;
            r_digit    <= n_digit;
            r_colon    <= n_colon;
            r_nonempty <= n_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_byte <= emit_byte;
            r_out_kind <= emit_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_kind      = r_out_kind;

endmodule

`default_nettype wire

>>> sv/hcbd_checker.sv
// Port-level checker for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "http_chunked_body_decoder_core_assert.svh"

module hcbd_checker
    import hcbd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic [2:0] o_kind
);

    logic out_wait;
    logic marker_kind;

    assign out_wait    = o_out_valid && !i_out_ready;
    assign marker_kind = o_kind != KIND_BODY && o_kind != KIND_TRAILER;

    `HCBD_ASSERT(a_out_hold, out_wait |=> o_out_valid)
    `HCBD_ASSERT(a_out_stable, out_wait |=> $stable(o_out_byte) && $stable(o_kind))
    `HCBD_ASSERT(a_marker_zero, o_out_valid && marker_kind |-> o_out_byte == 8'd0)
    `HCBD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_kind      (o_kind)
);

`default_nettype wire

>>> bench/tb_http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps
// Self-checking bench for http_chunked_body_decoder_core. It sends chunked message bytes with
// random gaps and stalls, predicts every result in step and compares each one as it comes out.
// It depends on hcbd_pkg and the decoder core.

module tb_http_chunked_body_decoder_core;
    import hcbd_pkg::*;

    localparam int CNT_W        = COUNT_BITS_DEF;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 350;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
    } t_decoded;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       restart;
    logic       out_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_kind;

    t_decoded   decoded_q[$];
    logic [7:0] msg_bytes[$];
    int         failures;
    int         idle_cycles;
    bit         no_idle;

    t_phase           ph;
    logic [CNT_W-1:0] remaining;
    bit               digit_seen;
    bit               colon_seen;
    bit               line_nonempty;

    http_chunked_body_decoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (in_byte),
        .i_restart   (restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) begin
            return int'(b) - 'h30;
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            return int'(b) - 'h41 + 10;
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            return int'(b) - 'h61 + 10;
        end
        return -1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic rst,
                                       output t_decoded res);
        int d;
        res = '0;
        if (rst) begin
            ph            = PH_SIZE;
            remaining     = '0;
            digit_seen    = 1'b0;
            colon_seen    = 1'b0;
            line_nonempty = 1'b0;
        end
        case (ph)
            PH_SIZE: begin
                if (b == BYTE_CR) begin
                    ph = PH_SIZE_LF;
                    return 1'b0;
                end
                d = hex_nibble(b);
                if (d < 0 || remaining[CNT_W-1 -: 4] != 4'd0) begin
                    ph       = PH_ERR;
                    res.kind = KIND_SIZE_ERR;
                    return 1'b1;
                end
                remaining  = {remaining[CNT_W-5:0], 4'(d)};
                digit_seen = 1'b1;
                return 1'b0;
            end
            PH_SIZE_LF: begin
                if (b != BYTE_LF || !digit_seen) begin
                    ph       = PH_ERR;
                    res.kind = KIND_SIZE_ERR;
                    return 1'b1;
                end
                digit_seen = 1'b0;
                if (remaining != '0) begin
                    ph = PH_DATA;
                end else begin
                    ph            = PH_TRL;
                    colon_seen    = 1'b0;
                    line_nonempty = 1'b0;
                end
                return 1'b0;
            end
            PH_DATA: begin
                remaining = remaining - 1'b1;
                if (remaining == '0) begin
                    ph = PH_DATA_CR;
                end
                res = '{data: b, kind: KIND_BODY};
                return 1'b1;
            end
            PH_DATA_CR: begin
                if (b != BYTE_CR) begin
                    ph       = PH_ERR;
                    res.kind = KIND_SIZE_ERR;
                    return 1'b1;
                end
                ph = PH_DATA_LF;
                return 1'b0;
            end
            PH_DATA_LF: begin
                if (b != BYTE_LF) begin
                    ph       = PH_ERR;
                    res.kind = KIND_SIZE_ERR;
                    return 1'b1;
                end
                ph         = PH_SIZE;
                remaining  = '0;
                digit_seen = 1'b0;
                return 1'b0;
            end
            PH_TRL: begin
                if (b == BYTE_CR) begin
                    if (!line_nonempty) begin
                        ph = PH_END_LF;
                        return 1'b0;
                    end
                    if (!colon_seen) begin
                        ph       = PH_ERR;
                        res.kind = KIND_TRAILER_ERR;
                        return 1'b1;
                    end
                    ph = PH_TRL_LF;
                    return 1'b0;
                end
                if (b == BYTE_COLON && !colon_seen) begin
                    if (!line_nonempty) begin
                        ph       = PH_ERR;
                        res.kind = KIND_TRAILER_ERR;
                        return 1'b1;
                    end
                    colon_seen = 1'b1;
                end
                line_nonempty = 1'b1;
                res = '{data: b, kind: KIND_TRAILER};
                return 1'b1;
            end
            PH_TRL_LF: begin
                if (b != BYTE_LF) begin
                    ph       = PH_ERR;
                    res.kind = KIND_TRAILER_ERR;
                    return 1'b1;
                end
                ph            = PH_TRL;
                colon_seen    = 1'b0;
                line_nonempty = 1'b0;
                res.kind      = KIND_LINE_END;
                return 1'b1;
            end
            PH_END_LF: begin
                if (b != BYTE_LF) begin
                    ph       = PH_ERR;
                    res.kind = KIND_TRAILER_ERR;
                    return 1'b1;
                end
                ph       = PH_DONE;
                res.kind = KIND_COMPLETE;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic rst);
        int       gap;
        t_decoded res;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        restart  <= rst;
        do @(posedge i_clk); while (!o_in_ready);
        if (decode_byte(b, rst, res)) begin
            decoded_q.push_back(res);
        end
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [7:0] s[$], input logic rst_first);
        foreach (s[i]) begin
            send_byte(s[i], (i == 0) ? rst_first : 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic push_hex(input logic [31:0] v);
        int         nd;
        int         zeros;
        logic [3:0] nib;
        nd = 1;
        while (nd < 8 && (v >> (4 * nd)) != 0) begin
            nd++;
        end
        zeros = $urandom_range(0, 2);
        repeat (zeros) msg_bytes.push_back(8'h30);
        for (int i = nd - 1; i >= 0; i--) begin
            nib = v[4 * i +: 4];
            if (nib < 4'd10) begin
                msg_bytes.push_back(8'h30 + nib);
            end else begin
                msg_bytes.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
            end
        end
    endtask

    function automatic logic [7:0] random_text_byte(input bit allow_colon);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == BYTE_CR || (!allow_colon && b == BYTE_COLON));
        return b;
    endfunction

    task automatic build_message();
        int size;
        int nchunks;
        int ntrl;
        msg_bytes.delete();
        nchunks = $urandom_range(0, 3);
        repeat (nchunks) begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300)
                                               : $urandom_range(1, 6);
            push_hex(size);
            msg_bytes.push_back(BYTE_CR);
            msg_bytes.push_back(BYTE_LF);
            repeat (size) msg_bytes.push_back(8'($urandom_range(0, 255)));
            msg_bytes.push_back(BYTE_CR);
            msg_bytes.push_back(BYTE_LF);
        end
        push_hex(0);
        msg_bytes.push_back(BYTE_CR);
        msg_bytes.push_back(BYTE_LF);
        ntrl = $urandom_range(0, 2);
        repeat (ntrl) begin
            repeat ($urandom_range(1, 4)) msg_bytes.push_back(random_text_byte(1'b0));
            msg_bytes.push_back(BYTE_COLON);
            repeat ($urandom_range(0, 4)) msg_bytes.push_back(random_text_byte(1'b1));
            msg_bytes.push_back(BYTE_CR);
            msg_bytes.push_back(BYTE_LF);
        end
        msg_bytes.push_back(BYTE_CR);
        msg_bytes.push_back(BYTE_LF);
    endtask

    task automatic test_complete_message();
        msg_bytes = {8'h31, BYTE_CR, BYTE_LF, 8'hFF, BYTE_CR, BYTE_LF,
                     8'h30, BYTE_CR, BYTE_LF, 8'h41, BYTE_COLON, 8'h00, BYTE_CR, BYTE_LF,
                     BYTE_CR, BYTE_LF, 8'h7A};
        send_seq(msg_bytes, 1'b1);
    endtask

    task automatic test_size_line_errors();
        msg_bytes = {BYTE_CR, BYTE_LF};
        send_seq(msg_bytes, 1'b1);
        msg_bytes = {8'h20, 8'h31};
        send_seq(msg_bytes, 1'b1);
        msg_bytes = {8'h66, 8'h46, 8'h66, 8'h46, 8'h66, 8'h46, 8'h66, 8'h46};
        send_seq(msg_bytes, 1'b1);
        msg_bytes = {8'h31, BYTE_CR, 8'h78};
        send_seq(msg_bytes, 1'b1);
        msg_bytes = {8'h31, BYTE_CR, BYTE_LF, 8'h00, 8'h78};
        send_seq(msg_bytes, 1'b1);
    endtask

    task automatic test_trailer_errors();
        msg_bytes = {8'h30, BYTE_CR, BYTE_LF, BYTE_COLON};
        send_seq(msg_bytes, 1'b1);
        msg_bytes = {8'h30, BYTE_CR, BYTE_LF, 8'h61, BYTE_CR};
        send_seq(msg_bytes, 1'b1);
        msg_bytes = {8'h30, BYTE_CR, BYTE_LF, BYTE_CR, 8'h78};
        send_seq(msg_bytes, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          next_pause;
        int          choice;
        int          cut;
        logic [31:0] big;
        sent       = 0;
        next_pause = 100;
        while (sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            choice  = $urandom_range(0, 9);
            if (choice <= 6) begin
                build_message();
                if ($urandom_range(0, 3) == 0) begin
                    msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 7) == 0) begin
                    cut = $urandom_range(0, msg_bytes.size() - 1);
                    msg_bytes = msg_bytes[0:cut];
                end
            end else if (choice <= 8) begin
                msg_bytes.delete();
                case ($urandom_range(0, 2))
                    0:       big = 32'h7FFF_FFFF;
                    1:       big = 32'h8000_0000;
                    default: big = $urandom();
                endcase
                push_hex(big);
                msg_bytes.push_back(BYTE_CR);
                msg_bytes.push_back(BYTE_LF);
                repeat (3) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                msg_bytes.delete();
                repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            sent += msg_bytes.size();
            if (choice == 9) begin
                foreach (msg_bytes[i]) begin
                    send_byte(msg_bytes[i], 1'($urandom_range(0, 1)));
                end
            end else begin
                repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 255)));
                send_seq(msg_bytes, 1'b1);
            end
            if (sent >= next_pause) begin
                wait_drained();
                next_pause += 100;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : result_checker
        int       stall;
        t_decoded want;
        out_ready = 1'b0;
        failures  = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (decoded_q.size() == 0) begin
                $error("unexpected result: out_byte=%0h kind=%0d", o_out_byte, o_kind);
                failures++;
            end else begin
                want = decoded_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %0h, actual %0h", want.data, o_out_byte);
                    failures++;
                end
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, o_kind);
                    failures++;
                end
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_http_chunked_body_decoder_core failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        restart     = 1'b0;
        no_idle     = 1'b0;
        ph            = PH_SIZE;
        remaining     = '0;
        digit_seen    = 1'b0;
        colon_seen    = 1'b0;
        line_nonempty = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_complete_message();
        test_size_line_errors();
        test_trailer_errors();
        test_random_traffic();
        wait_drained();
        if (failures == 0 && decoded_q.size() == 0) begin
            $display("tb_http_chunked_body_decoder_core passed");
        end else begin
            $display("tb_http_chunked_body_decoder_core failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/hcbd_pkg.sv
sv/http_chunked_body_decoder_core.sv
sv/hcbd_checker.sv
bench/tb_http_chunked_body_decoder_core.sv
